FILE: src/stepper_trapezoid_ramp_assert.svh
// Assertion macros used by the checker file of the stepper ramp.
`ifndef STEPPER_TRAPEZOID_RAMP_ASSERT_SVH
`define STEPPER_TRAPEZOID_RAMP_ASSERT_SVH

// Antecedent holds, consequent holds in the same cycle.
`define STRAMP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stepper ramp check failed");

// Antecedent holds, consequent holds in the next cycle.
`define STRAMP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stepper ramp check failed");

`endif

FILE: src/stramp_pkg.sv
// ----------------------------------------------------------------------------
// stramp_pkg
// Shared constants, codes and widths of the trapezoidal stepper ramp.
// ----------------------------------------------------------------------------
`default_nettype none
package stramp_pkg;

   localparam int SPEED_FRAC_BITS_DEF = 16;
   localparam int SPEED_W = 42;
   localparam logic [SPEED_W-1:0] SPEED_LIMIT = {SPEED_W{1'b1}};

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_FIELDS_W = 69;
   localparam int RSP_TDATA_W = 72;

   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONGEST_HALF = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCELERATION = 2'd3;

   localparam logic [2:0] ACT_COMPARE = 3'd0;
   localparam logic [2:0] ACT_REL_MOVE = 3'd1;
   localparam logic [2:0] ACT_ABS_MOVE = 3'd2;
   localparam logic [2:0] ACT_SMOOTH_STOP = 3'd3;
   localparam logic [2:0] ACT_EMERG_STOP = 3'd4;
   localparam logic [2:0] ACT_TARE = 3'd5;

endpackage
`default_nettype wire

FILE: src/stramp_div.sv
// ----------------------------------------------------------------------------
// stramp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module stramp_div #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 43
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [NUM_W-1:0] quo,
   output logic                  done
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in;
   logic [DEN_W:0]   rem_ff, rem_in, trial;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             ge;

   always_comb begin
      trial = {rem_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      ge = trial >= {1'b0, den_ff};
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      q_in = q_ff;
      den_in = den_ff;
      if (start) begin
         cnt_in = CNT_W'(NUM_W);
         run_in = 1'b1;
         rem_in = '0;
         q_in = num;
         den_in = den;
      end else if (run_ff) begin
         rem_in = ge ? (trial - {1'b0, den_ff}) : trial;
         q_in = {q_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff <= q_in;
      den_ff <= den_in;
   end

   assign quo = q_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

FILE: src/stramp_mul.sv
// ----------------------------------------------------------------------------
// stramp_mul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module stramp_mul #(
   parameter int OP_W = 42
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [OP_W-1:0]   op_a,
   input  wire logic [OP_W-1:0]   op_b,
   output logic      [2*OP_W-1:0] prod,
   output logic                   done
);
   localparam int CNT_W = $clog2(OP_W + 1);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in, done_ff, done_in;
   logic [OP_W-1:0]   a_ff, a_in;
   logic [2*OP_W-1:0] b_ff, b_in, acc_ff, acc_in;

   always_comb begin
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      if (start) begin
         cnt_in = CNT_W'(OP_W);
         run_in = 1'b1;
         a_in = op_a;
         b_in = (2*OP_W)'(op_b);
         acc_in = '0;
      end else if (run_ff) begin
         if (a_ff[0]) begin
            acc_in = acc_ff + b_ff;
         end
         a_in = a_ff >> 1;
         b_in = b_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
   end

   assign prod = acc_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

FILE: src/stramp_sqrt.sv
// ----------------------------------------------------------------------------
// stramp_sqrt
// Digit-by-digit integer square root, one root bit per cycle, truncated.
// ----------------------------------------------------------------------------
`default_nettype none
module stramp_sqrt #(
   parameter int ROOT_W = 43
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [2*ROOT_W-1:0] radicand,
   output logic      [ROOT_W-1:0]   root,
   output logic                     done
);
   localparam int CNT_W = $clog2(ROOT_W + 1);
   localparam int REM_W = ROOT_W + 2;

   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                run_ff, run_in, done_ff, done_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [2*ROOT_W-1:0] rad_ff, rad_in;
   logic [REM_W+1:0]    cand, trial;
   logic                ge;

   always_comb begin
      cand = {rem_ff, rad_ff[2*ROOT_W-1 -: 2]};
      trial = (REM_W+2)'({root_ff, 2'b01});
      ge = cand >= trial;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      root_in = root_ff;
      rad_in = rad_ff;
      if (start) begin
         cnt_in = CNT_W'(ROOT_W);
         run_in = 1'b1;
         rem_in = '0;
         root_in = '0;
         rad_in = radicand;
      end else if (run_ff) begin
         rem_in = REM_W'(ge ? (cand - trial) : cand);
         root_in = {root_ff[ROOT_W-2:0], ge};
         rad_in = rad_ff << 2;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      root_ff <= root_in;
      rad_ff <= rad_in;
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

FILE: src/stepper_trapezoid_ramp.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp
// Trapezoidal step/direction profile: one action per beat, one result beat.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  req_      in         action in tuser; move_steps, absolute_target in tdata
//  rsp_      out        accepted, level, direction, moving, position, arm, interval
//  csr_      in         write of tick_rate, longest half period, max speed, accel
//
//  Plain actions pass through ST_REPLY, the hold register and the output
//  register. A move start runs two or three passes of the bit-serial divider.
//  A rising step edge adds two multiplier passes and at most one square root
//  pass. Reset is synchronous and leaves no clearing pass. One result is
//  buffered, so the next beat is taken while the previous result waits on
//  rsp_tready.
// ----------------------------------------------------------------------------
`default_nettype none
module stepper_trapezoid_ramp #(
   parameter int SPEED_FRAC_BITS = stramp_pkg::SPEED_FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // move_steps [31:0], absolute_target [47:32]
   input  wire logic [stramp_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // action [2:0]
   input  wire logic [stramp_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // accepted [0], step_level [1], direction [2], moving [3], position [35:4],
   // arm_timer [36], interval_ticks [68:37], zero fill [71:69]
   output logic      [stramp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  wire logic                                csr_wen,
   input  wire logic [stramp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [stramp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import stramp_pkg::*;

   localparam int F = SPEED_FRAC_BITS;
   localparam int TS_W = 32 + F;
   localparam int WIDE_W = (TS_W > SPEED_W) ? TS_W : SPEED_W;
   localparam int NUM_W = WIDE_W + 1;
   localparam int DEN_W = SPEED_W + 1;
   localparam int PROD_W = 2 * SPEED_W;
   localparam int NEED_P_W = 65;
   localparam int NEED_W = NEED_P_W + 2 * F;
   localparam int CMP_W = (PROD_W > NEED_W) ? PROD_W : NEED_W;
   localparam int ACC2_W = 33 + 2 * F;
   localparam int RAD_W = ((PROD_W > ACC2_W) ? PROD_W : ACC2_W) + 1;
   localparam int ROOT_W = (RAD_W + 1) / 2;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_VMIN  = 9'b000000010,
      ST_SQ    = 9'b000000100,
      ST_NEED  = 9'b000001000,
      ST_ROOT  = 9'b000010000,
      ST_CLAMP = 9'b000100000,
      ST_HP    = 9'b001000000,
      ST_SPEED = 9'b010000000,
      ST_REPLY = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] tick_ff, lhp_ff, maxs_ff, acc_ff;
   logic [31:0] pos_ff, pos_in, left_ff, left_in, hp_ff, hp_in;
   logic        dir_ff, dir_in, busy_ff, busy_in, soft_ff, soft_in, pin_ff, pin_in;
   logic        edge_ff, edge_in, dec_ff, dec_in, ok_ff, ok_in, arm_ff, arm_in;
   logic [SPEED_W-1:0] speed_ff, speed_in, vmin_ff, vmin_in;
   logic [PROD_W-1:0]  v2_ff, v2_in;
   logic [ROOT_W-1:0]  nv_ff, nv_in;

   logic                    hold_valid_ff, hold_valid_in, rsp_valid_ff;
   logic [RSP_FIELDS_W-1:0] hold_ff, rsp_data_ff;

   logic                accept;
   logic [2:0]          action;
   logic [31:0]         move_steps, target, delta, left_dec, arr, q_hp;
   logic [TS_W-1:0]     ts;
   logic [NUM_W-1:0]    ts_num;
   logic [WIDE_W-1:0]   ms_w;
   logic [SPEED_W-1:0]  msat, vmax, q_sat, v_sel, hp_src_v, v_clamp;
   logic [ACC2_W-1:0]   acc2;
   logic [RAD_W-1:0]    v2_rad, acc2_rad;
   logic [NEED_W-1:0]   need_cmp;
   logic                decel;

   logic                div_start, div_done;
   logic [NUM_W-1:0]    div_num, div_quo;
   logic [DEN_W-1:0]    div_den;
   logic                mul_start, mul_done;
   logic [SPEED_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0]   mul_prod;
   logic                sq_start, sq_done;
   logic [2*ROOT_W-1:0] sq_rad;
   logic [ROOT_W-1:0]   sq_root;

   stramp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .quo(div_quo), .done(div_done)
   );

   stramp_mul #(.OP_W(SPEED_W)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_a(mul_a),
      .op_b(mul_b), .prod(mul_prod), .done(mul_done)
   );

   stramp_sqrt #(.ROOT_W(ROOT_W)) u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_rad),
      .root(sq_root), .done(sq_done)
   );

   assign req_tready = (state_ff == ST_IDLE) && !hold_valid_ff;
   assign accept = req_tvalid && req_tready;
   assign action = req_tuser;
   assign move_steps = req_tdata[31:0];

   always_comb begin
      arr = (lhp_ff == 32'd0) ? 32'd1 : lhp_ff;
      ts = {tick_ff, {F{1'b0}}};
      ts_num = NUM_W'(ts);
      ms_w = WIDE_W'({maxs_ff, {F{1'b0}}});
      msat = (ms_w > WIDE_W'(SPEED_LIMIT)) ? SPEED_LIMIT : ms_w[SPEED_W-1:0];
      vmax = (msat < vmin_ff) ? vmin_ff : msat;
      q_sat = (div_quo > NUM_W'(SPEED_LIMIT)) ? SPEED_LIMIT : div_quo[SPEED_W-1:0];
      if (div_quo == '0) begin
         q_hp = 32'd1;
      end else if (div_quo > NUM_W'(arr)) begin
         q_hp = arr;
      end else begin
         q_hp = div_quo[31:0];
      end
      v_sel = (speed_ff < q_sat) ? q_sat : speed_ff;
      acc2 = {acc_ff, 1'b0, {(2*F){1'b0}}};
      v2_rad = RAD_W'(v2_ff);
      acc2_rad = RAD_W'(acc2);
      need_cmp = {mul_prod[NEED_P_W-1:0], {(2*F){1'b0}}};
      decel = soft_ff || (CMP_W'(v2_ff) >= CMP_W'(need_cmp));
      if (dec_ff) begin
         v_clamp = (nv_ff < ROOT_W'(vmin_ff)) ? vmin_ff : nv_ff[SPEED_W-1:0];
      end else begin
         v_clamp = (nv_ff > ROOT_W'(vmax)) ? vmax : nv_ff[SPEED_W-1:0];
      end
      hp_src_v = (state_ff == ST_VMIN) ? q_sat : v_clamp;
      target = (action == ACT_REL_MOVE) ? (pos_ff + move_steps) : {16'd0, req_tdata[47:32]};
      delta = target - pos_ff;
      left_dec = (left_ff != 32'd0) ? (left_ff - 32'd1) : 32'd0;
   end

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      left_in = left_ff;
      hp_in = hp_ff;
      dir_in = dir_ff;
      busy_in = busy_ff;
      soft_in = soft_ff;
      pin_in = pin_ff;
      edge_in = edge_ff;
      dec_in = dec_ff;
      ok_in = ok_ff;
      arm_in = arm_ff;
      speed_in = speed_ff;
      vmin_in = vmin_ff;
      v2_in = v2_ff;
      nv_in = nv_ff;
      hold_valid_in = hold_valid_ff;
      div_start = 1'b0;
      div_num = ts_num + NUM_W'(arr);
      div_den = DEN_W'({arr, 1'b0});
      mul_start = 1'b0;
      mul_a = v_sel;
      mul_b = v_sel;
      sq_start = 1'b0;
      sq_rad = (2*ROOT_W)'(v2_rad + acc2_rad);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ok_in = 1'b1;
               arm_in = 1'b0;
               state_in = ST_REPLY;
               unique case (action)
                  ACT_COMPARE: begin
                     if (busy_ff) begin
                        pin_in = !pin_ff;
                        arm_in = 1'b1;
                        if (!pin_ff) begin
                           pos_in = dir_ff ? (pos_ff + 32'd1) : (pos_ff - 32'd1);
                           left_in = left_dec;
                           if (left_dec == 32'd0) begin
                              busy_in = 1'b0;
                              soft_in = 1'b0;
                              pin_in = 1'b0;
                              hp_in = '0;
                              speed_in = '0;
                              arm_in = 1'b0;
                           end else begin
                              edge_in = 1'b1;
                              div_start = 1'b1;
                              state_in = ST_VMIN;
                           end
                        end
                     end
                  end
                  ACT_REL_MOVE, ACT_ABS_MOVE: begin
                     if (busy_ff) begin
                        ok_in = 1'b0;
                     end else if (delta != 32'd0) begin
                        dir_in = !delta[31];
                        left_in = delta[31] ? (32'd0 - delta) : delta;
                        soft_in = 1'b0;
                        pin_in = 1'b0;
                        busy_in = 1'b1;
                        arm_in = 1'b1;
                        edge_in = 1'b0;
                        div_start = 1'b1;
                        state_in = ST_VMIN;
                     end
                  end
                  ACT_SMOOTH_STOP: begin
                     soft_in = 1'b1;
                  end
                  ACT_EMERG_STOP: begin
                     busy_in = 1'b0;
                     soft_in = 1'b0;
                     pin_in = 1'b0;
                     hp_in = '0;
                     speed_in = '0;
                     left_in = '0;
                  end
                  ACT_TARE: begin
                     if (!busy_ff) begin
                        pos_in = '0;
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_VMIN: begin
            if (div_done) begin
               vmin_in = q_sat;
               if (edge_ff) begin
                  mul_start = 1'b1;
                  state_in = ST_SQ;
               end else if (hp_src_v == '0) begin
                  hp_in = arr;
                  div_start = 1'b1;
                  state_in = ST_SPEED;
               end else begin
                  div_num = ts_num + NUM_W'(hp_src_v);
                  div_den = {hp_src_v, 1'b0};
                  div_start = 1'b1;
                  state_in = ST_HP;
               end
            end
         end
         ST_SQ: begin
            if (mul_done) begin
               v2_in = mul_prod;
               mul_a = SPEED_W'({acc_ff, 1'b0});
               mul_b = SPEED_W'(left_ff);
               mul_start = 1'b1;
               state_in = ST_NEED;
            end
         end
         ST_NEED: begin
            if (mul_done) begin
               dec_in = decel;
               if (decel) begin
                  if (acc2_rad >= v2_rad) begin
                     nv_in = '0;
                     state_in = ST_CLAMP;
                  end else begin
                     sq_rad = (2*ROOT_W)'(v2_rad - acc2_rad);
                     sq_start = 1'b1;
                     state_in = ST_ROOT;
                  end
               end else begin
                  sq_start = 1'b1;
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            if (sq_done) begin
               nv_in = sq_root;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (dec_ff && soft_ff && (nv_ff <= ROOT_W'(vmin_ff))) begin
               busy_in = 1'b0;
               soft_in = 1'b0;
               pin_in = 1'b0;
               hp_in = '0;
               speed_in = '0;
               left_in = '0;
               arm_in = 1'b0;
               state_in = ST_REPLY;
            end else if (hp_src_v == '0) begin
               hp_in = arr;
               div_start = 1'b1;
               state_in = ST_SPEED;
            end else begin
               div_num = ts_num + NUM_W'(hp_src_v);
               div_den = {hp_src_v, 1'b0};
               div_start = 1'b1;
               state_in = ST_HP;
            end
         end
         ST_HP: begin
            if (div_done) begin
               hp_in = q_hp;
               div_num = ts_num + NUM_W'(q_hp);
               div_den = DEN_W'({q_hp, 1'b0});
               div_start = 1'b1;
               state_in = ST_SPEED;
            end
         end
         ST_SPEED: begin
            if (div_done) begin
               speed_in = q_sat;
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            hold_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (hold_valid_ff && (!rsp_valid_ff || rsp_tready)) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tick_ff <= 32'd1000000;
         lhp_ff <= 32'd65535;
         maxs_ff <= 32'd1000;
         acc_ff <= 32'd1000;
         pos_ff <= '0;
         left_ff <= '0;
         hp_ff <= '0;
         dir_ff <= 1'b1;
         busy_ff <= 1'b0;
         soft_ff <= 1'b0;
         pin_ff <= 1'b0;
         speed_ff <= '0;
         edge_ff <= 1'b0;
         dec_ff <= 1'b0;
         ok_ff <= 1'b0;
         arm_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         left_ff <= left_in;
         hp_ff <= hp_in;
         dir_ff <= dir_in;
         busy_ff <= busy_in;
         soft_ff <= soft_in;
         pin_ff <= pin_in;
         speed_ff <= speed_in;
         edge_ff <= edge_in;
         dec_ff <= dec_in;
         ok_ff <= ok_in;
         arm_ff <= arm_in;
         hold_valid_ff <= hold_valid_in;
         if (hold_valid_ff && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wen) begin
            unique case (csr_index)
               CSR_TICK_RATE:    tick_ff <= csr_wdata;
               CSR_LONGEST_HALF: lhp_ff <= csr_wdata;
               CSR_MAX_SPEED:    maxs_ff <= csr_wdata;
               CSR_ACCELERATION: acc_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      vmin_ff <= vmin_in;
      v2_ff <= v2_in;
      nv_ff <= nv_in;
      if (state_ff == ST_REPLY) begin
         hold_ff <= {(arm_ff ? hp_ff : 32'd0), arm_ff, pos_ff, busy_ff, dir_ff, pin_ff, ok_ff};
      end
      if (hold_valid_ff && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= hold_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_TDATA_W-RSP_FIELDS_W){1'b0}}, rsp_data_ff};
endmodule
`default_nettype wire

FILE: src/stramp_check.sv
// ----------------------------------------------------------------------------
// stramp_check
// Port-level checks of the stepper ramp, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stepper_trapezoid_ramp_assert.svh"
module stramp_check (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [stramp_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   `STRAMP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `STRAMP_ASSERT_NOW(a_idle_interval, rsp_tvalid && !rsp_tdata[36], rsp_tdata[68:37] == 32'd0)
   `STRAMP_ASSERT_NOW(a_armed_interval, rsp_tvalid && rsp_tdata[36], rsp_tdata[68:37] != 32'd0)
   `STRAMP_ASSERT_NOW(a_stopped_pin, rsp_tvalid && !rsp_tdata[3], !rsp_tdata[1])
   `STRAMP_ASSERT_NOW(a_armed_moving, rsp_tvalid && rsp_tdata[36], rsp_tdata[3] && rsp_tdata[0])
endmodule

bind stepper_trapezoid_ramp stramp_check u_stramp_check (.*);
`default_nettype wire
